// File: rtl/mds_pkg.sv
// ----------------------------------------------------------------------------
// mds_pkg: shared types and constants of the motion delta splitter
// lane command struct, fixed field widths and the sample size limits
// ----------------------------------------------------------------------------
package mds_pkg;

  localparam int PosW       = 20;
  localparam int DeltaW     = 21;
  localparam int PartW      = 16;
  localparam int IdxW       = 12;
  localparam int SplitW     = 6;
  localparam int CarriedAxes = 4;
  localparam int DefNumAxes = 4;
  localparam int DefMaxSamples = 4096;
  localparam logic signed [PartW-1:0] PartMax = 16'sd32767;
  localparam logic signed [PartW-1:0] PartMin = -16'sd32768;
  localparam logic [DeltaW-1:0] SplitUnit = 21'd32767;
  localparam logic [DeltaW-1:0] SplitBias = 21'd32766;
  localparam logic [DeltaW-1:0] PosMagMax = 21'd32767;
  localparam logic [DeltaW-1:0] NegMagMax = 21'd32768;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COUNT,
    ST_CHECK,
    ST_DIV,
    ST_EMIT,
    ST_STORE,
    ST_TAIL
  } state_t;

  // command from the sequencer to each lane
  typedef struct packed {
    logic              start;
    logic [SplitW-1:0] splits;
  } lane_cmd_t;

endpackage

// File: rtl/mds_lane.sv
// ----------------------------------------------------------------------------
// mds_lane: per-axis divider lane
// restoring division of |delta| by the split count, one quotient bit a cycle
// ----------------------------------------------------------------------------
module mds_lane import mds_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  lane_cmd_t                cmd,
  input  logic signed [DeltaW-1:0] delta,
  output logic signed [PartW-1:0]  part_mid,
  output logic signed [PartW-1:0]  part_end,
  output logic                     done
);

  logic [DeltaW-1:0] mag;
  logic [DeltaW-1:0] quo;
  logic [SplitW:0]   rem;
  logic [4:0]        cnt;
  logic              busy;
  logic              neg;
  logic [SplitW:0]   trial;
  logic [DeltaW-1:0] quo_sh;
  logic [DeltaW-1:0] end_mag;

  assign trial  = {rem[SplitW-1:0], mag[DeltaW-1]};
  assign quo_sh = {quo[DeltaW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      cnt  <= 5'(DeltaW);
      mag  <= delta[DeltaW-1] ? DeltaW'(-delta) : delta;
      neg  <= delta[DeltaW-1];
      quo  <= '0;
      rem  <= '0;
    end else if (busy) begin
      mag <= {mag[DeltaW-2:0], 1'b0};
      if (trial >= {1'b0, cmd.splits}) begin
        rem <= trial - {1'b0, cmd.splits};
        quo <= quo_sh | DeltaW'(1);
      end else begin
        rem <= trial;
        quo <= quo_sh;
      end
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) busy <= 1'b0;
    end
  end

  assign done = !busy;

  // last part is delta - q * (splits - 1), whose magnitude is quo + rem
  assign end_mag = quo + DeltaW'(rem);

  // |delta| never exceeds 32767 * splits, so the middle part fits
  assign part_mid = $signed(PartW'(neg ? -quo : quo));

  always_comb begin
    if (!neg) begin
      if (end_mag > PosMagMax) part_end = PartMax;
      else part_end = $signed(PartW'(end_mag));
    end else begin
      if (end_mag > NegMagMax) part_end = PartMin;
      else part_end = $signed(PartW'(-end_mag));
    end
  end

endmodule

// File: rtl/motion_delta_splitter_core.sv
// ----------------------------------------------------------------------------
// motion_delta_splitter_core: frame to delta sample splitter
// ----------------------------------------------------------------------------
// Takes one frame of absolute axis positions per input word and emits the
// motion from the previous frame as 16-bit per-axis delta words, split into
// ceil(max |delta| / 32767) words, at least one. The input is stalled from the
// accepting edge until the frame is done. A frame with no previous frame is
// only stored. Otherwise the block finds the largest delta, then the split
// count, then runs the capacity check that also starts the lanes, waits until
// the divider lanes (21 quotient bits, one a cycle) are all done, emits one
// word per split (up to 33) and stores the frame. A last frame adds its
// closing zero word, a failed path returns straight to idle, and a capacity
// overflow emits one overflow word instead. Sample-side stalls hold every word.
// ----------------------------------------------------------------------------
module motion_delta_splitter_core import mds_pkg::*; #(
  parameter int NUM_AXES    = DefNumAxes,
  parameter int MAX_SAMPLES = DefMaxSamples
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [PosW-1:0]  pos_0,
  input  logic signed [PosW-1:0]  pos_1,
  input  logic signed [PosW-1:0]  pos_2,
  input  logic signed [PosW-1:0]  pos_3,
  input  logic                    first_frame,
  input  logic                    last_frame,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [PartW-1:0] part_0,
  output logic signed [PartW-1:0] part_1,
  output logic signed [PartW-1:0] part_2,
  output logic signed [PartW-1:0] part_3,
  output logic [IdxW-1:0]         sample_index,
  output logic                    frame_start,
  output logic                    run_last,
  output logic                    overflow
);

  localparam int CntW = $clog2(MAX_SAMPLES + 1) + 1;
  localparam int LimA = (NUM_AXES < CarriedAxes) ? NUM_AXES : CarriedAxes;

  state_t state, state_next;
  logic [2:0]  axis_count;
  logic signed [PosW-1:0] prev [CarriedAxes];
  logic signed [PosW-1:0] cur  [CarriedAxes];
  logic signed [DeltaW-1:0] delta [CarriedAxes];
  logic        have_prev, failed, last_q;
  logic [CntW-1:0] sample_count;
  logic [SplitW-1:0] splits, splits_next, s_idx;
  logic [DeltaW-1:0] max_abs, max_q, ceil_sum;
  logic [PartW-1:0]  ceil_rem;
  logic [2:0]  naxes;
  lane_cmd_t   cmd;
  logic        start_div, out_load;
  logic signed [PartW-1:0] pmid [CarriedAxes];
  logic signed [PartW-1:0] pend [CarriedAxes];
  logic [CarriedAxes-1:0]  ldone;
  logic        take, out_free, s_last, group_ovf, tail_ovf;

  assign cfg_ready = (state == ST_IDLE) && !out_valid;
  assign in_stall  = (state != ST_IDLE);
  assign take      = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    naxes = (axis_count == 3'd0) ? 3'd1 : axis_count;
    if (naxes > 3'(LimA)) naxes = 3'(LimA);
  end

  // deltas and max over the active axes, computed from captured words
  always_comb begin
    max_abs = '0;
    for (int a = 0; a < CarriedAxes; a++) begin
      if (3'(a) < naxes) delta[a] = DeltaW'(cur[a]) - DeltaW'(prev[a]);
      else delta[a] = '0;
      if ((delta[a][DeltaW-1] ? DeltaW'(-delta[a]) : delta[a]) > max_abs)
        max_abs = delta[a][DeltaW-1] ? DeltaW'(-delta[a]) : delta[a];
    end
  end

  // ceil(max / 32767): the divisor is 2^15 - 1, so the high bits give the
  // quotient and one compare on the folded low part corrects it
  assign ceil_sum = max_q + SplitBias;
  assign ceil_rem = PartW'(ceil_sum[PartW-2:0]) + PartW'(ceil_sum[DeltaW-1:PartW-1]);
  assign splits_next = (max_q > SplitUnit)
                       ? ceil_sum[DeltaW-1:PartW-1] + SplitW'(ceil_rem >= PartW'(SplitUnit))
                       : SplitW'(1);

  assign group_ovf = (sample_count + CntW'(splits)) > CntW'(MAX_SAMPLES);
  assign tail_ovf  = (sample_count + CntW'(1)) > CntW'(MAX_SAMPLES);
  assign s_last    = (s_idx == splits - SplitW'(1));

  assign cmd = '{start: start_div, splits: splits};

  for (genvar g = 0; g < CarriedAxes; g++) begin : g_lane
    mds_lane u_lane (
      .clk(clk), .rst(rst), .cmd(cmd), .delta(delta[g]),
      .part_mid(pmid[g]), .part_end(pend[g]), .done(ldone[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    start_div  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: if (take) state_next = ST_EVAL;
      ST_EVAL: begin
        if (failed) state_next = ST_IDLE;
        else if (!have_prev) state_next = ST_STORE;
        else state_next = ST_COUNT;
      end
      ST_COUNT: state_next = ST_CHECK;
      ST_CHECK: begin
        if (group_ovf) begin
          if (out_free) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          start_div  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: if (&ldone) state_next = ST_EMIT;
      ST_EMIT: if (out_free) begin
        out_load = 1'b1;
        if (s_last) state_next = ST_STORE;
      end
      ST_STORE: state_next = last_q ? ST_TAIL : ST_IDLE;
      ST_TAIL: if (out_free) begin
        out_load   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_count   <= 3'd1;
      have_prev    <= 1'b0;
      failed       <= 1'b0;
      sample_count <= '0;
      out_valid    <= 1'b0;
      for (int a = 0; a < CarriedAxes; a++) prev[a] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) axis_count <= cfg_data;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (take) begin
          cur[0] <= pos_0; cur[1] <= pos_1; cur[2] <= pos_2; cur[3] <= pos_3;
          last_q <= last_frame;
          if (first_frame) begin
            sample_count <= '0; failed <= 1'b0; have_prev <= 1'b0;
          end
        end
        ST_EVAL: max_q <= max_abs;
        ST_COUNT: splits <= splits_next;
        ST_CHECK: begin
          if (group_ovf) begin
            if (out_free) begin
              part_0 <= '0; part_1 <= '0; part_2 <= '0; part_3 <= '0;
              sample_index <= IdxW'(sample_count);
              frame_start <= 1'b0; run_last <= 1'b1; overflow <= 1'b1;
              failed <= 1'b1;
            end
          end else begin
            s_idx <= '0;
          end
        end
        ST_EMIT: if (out_free) begin
          part_0 <= s_last ? pend[0] : pmid[0];
          part_1 <= s_last ? pend[1] : pmid[1];
          part_2 <= s_last ? pend[2] : pmid[2];
          part_3 <= s_last ? pend[3] : pmid[3];
          sample_index <= IdxW'(sample_count);
          frame_start <= (s_idx == '0);
          overflow <= 1'b0;
          run_last <= s_last && !last_q;
          sample_count <= sample_count + CntW'(1);
          s_idx <= s_idx + SplitW'(1);
        end
        ST_STORE: begin
          for (int a = 0; a < CarriedAxes; a++) prev[a] <= cur[a];
          have_prev <= 1'b1;
        end
        ST_TAIL: if (out_free) begin
          part_0 <= '0; part_1 <= '0; part_2 <= '0; part_3 <= '0;
          sample_index <= IdxW'(sample_count); run_last <= 1'b1;
          have_prev <= 1'b0;
          if (tail_ovf) begin
            failed <= 1'b1; frame_start <= 1'b0; overflow <= 1'b1;
          end else begin
            frame_start <= 1'b1; overflow <= 1'b0;
            sample_count <= sample_count + CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) take |=> in_stall)
    else $error("took a word while busy");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> run_last)
    else $error("overflow word not last");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample_count <= CntW'(MAX_SAMPLES))
    else $error("sample count past capacity");

endmodule
